[src/pwmdc_pkg.sv]
// Shared types and constants for the PWM divider and edge calculator.
`default_nettype none
package pwmdc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned QuoW = 32;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_CHAN  = 3'd1,
    ST_ZERO_PER  = 3'd2,
    ST_PULSE_BIG = 3'd3,
    ST_DIV_BIG   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_CHANNEL_COUNT = 2'd0,
    CFG_PERIOD_BITS   = 2'd1,
    CFG_DIVIDER_BITS  = 2'd2
  } cfg_idx_e;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    status_e     status;
    logic [7:0]  chan;
    logic        pul_zero;
    logic        inv;
    logic [31:0] per;
    logic [31:0] pul;
    logic [5:0]  pbits;
  } job_t;

  // Result item.
  typedef struct packed {
    status_e     status;
    logic [7:0]  chan;
    logic        tvalid;
    logic [31:0] divv;
    logic [31:0] perv;
    logic [31:0] rise;
    logic [31:0] fall;
    logic        en;
    logic        invb;
  } res_t;

endpackage
`default_nettype wire

[src/pwmdc_fifo.sv]
// Small synchronous queue used between stages.
`default_nettype none
module pwmdc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == AW'(0) + (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule
`default_nettype wire

[src/pwmdc_front.sv]
// Front end: request checks in priority order, including the divider range check.
`default_nettype none
module pwmdc_front
  import pwmdc_pkg::*;
(
  input  wire logic [7:0]  chan_cnt_i,
  input  wire logic [5:0]  pbits_i,
  input  wire logic [5:0]  dbits_i,
  input  wire logic [7:0]  chan_i,
  input  wire logic [31:0] per_i,
  input  wire logic [31:0] pul_i,
  input  wire logic        inv_i,
  output job_t             job_o
);
  logic [5:0]  pb, db;
  logic        div_big;

  // With limit M = 2^pb, D = floor(per/(M+1)). The divider exceeds the
  // allowed maximum exactly when per >= (maxdiv+1)*(M+1); the divider
  // itself is computed exactly in the back end.
  logic [66:0] bound;

  always_comb begin
    pb = (pbits_i > 6'd32) ? 6'd32 : pbits_i;
    db = (dbits_i > 6'd32) ? 6'd32 : dbits_i;
    // (2^db)*(2^pb + 1) = 2^(db+pb) + 2^db : shifts only. The exponent
    // reaches 64, so it is summed in seven bits.
    bound = (67'd1 << (7'(db) + 7'(pb))) + (67'd1 << db);
    div_big = ({35'd0, per_i} >= bound);
    job_o.chan     = chan_i;
    job_o.per      = per_i;
    job_o.pul      = pul_i;
    job_o.inv      = inv_i;
    job_o.pul_zero = (pul_i == '0);
    job_o.pbits    = pb;
    priority if (chan_i >= chan_cnt_i) begin
      job_o.status = ST_BAD_CHAN;
    end else if (per_i == '0) begin
      job_o.status = ST_ZERO_PER;
    end else if (pul_i > per_i) begin
      job_o.status = ST_PULSE_BIG;
    end else if (div_big) begin
      job_o.status = ST_DIV_BIG;
    end else begin
      job_o.status = ST_OK;
    end
  end
endmodule
`default_nettype wire

[src/pwmdc_back.sv]
// Back end: pipelined restoring dividers for the divider and scaled values.
`default_nettype none
module pwmdc_back
  import pwmdc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  job_t      job_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output res_t      res_o,
  input  wire logic out_ready_i
);
  // Stage 0 only loads the request. Stages 1..32: D = per / (2^pb + 1),
  // one quotient bit a stage. Stages 33..64: per/(D+1) and pul/(D+1) in
  // parallel lanes.
  localparam int unsigned NA = 33;
  localparam int unsigned NB = 32;
  localparam int unsigned NS = NA + NB;

  typedef struct packed {
    job_t        job;
    logic [32:0] dvs;   // divisor
    logic [32:0] rp;    // remainder, period lane
    logic [31:0] qp;    // quotient / dividend shift, period lane
    logic [32:0] rq;    // remainder, pulse lane
    logic [31:0] qq;
    logic [31:0] dv;    // selected divider
  } stg_t;

  stg_t stg_in;
  stg_t stg_q [1:NS];
  logic vld_q [1:NS];
  logic adv;

  // Whole pipe advances together; a result leaves only into the output fifo.
  logic ofull, oempty;
  assign adv        = !(vld_q[NS] && ofull);
  assign in_ready_o = adv;

  always_comb begin
    stg_in     = '0;
    stg_in.job = job_i;
    stg_in.dvs = (33'd1 << job_i.pbits) + 33'd1;
    stg_in.qp  = job_i.per;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stg
    stg_t cur, nx;
    logic cur_vld;
    if (s == 0) begin : g_head
      assign cur     = stg_in;
      assign cur_vld = in_valid_i;
    end else begin : g_body
      assign cur     = stg_q[s];
      assign cur_vld = vld_q[s];
    end
    always_comb begin
      logic [33:0] tp, tq;
      nx = cur;
      if (s == NA) begin
        // Divider is final; set up the scaling lanes.
        nx.dv  = cur.qp;
        nx.dvs = {1'b0, cur.qp} + 33'd1;
        nx.rp  = '0;
        nx.qp  = cur.job.per;
        nx.rq  = '0;
        nx.qq  = cur.job.pul;
      end
      tp = {nx.rp, nx.qp[31]};
      tq = {nx.rq, nx.qq[31]};
      if (s > 0) begin
        if (tp >= {1'b0, nx.dvs}) begin
          nx.rp = 33'(tp - {1'b0, nx.dvs});
          nx.qp = {nx.qp[30:0], 1'b1};
        end else begin
          nx.rp = tp[32:0];
          nx.qp = {nx.qp[30:0], 1'b0};
        end
      end
      if (s >= NA) begin
        if (tq >= {1'b0, nx.dvs}) begin
          nx.rq = 33'(tq - {1'b0, nx.dvs});
          nx.qq = {nx.qq[30:0], 1'b1};
        end else begin
          nx.rq = tq[32:0];
          nx.qq = {nx.qq[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= cur_vld;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[s+1] <= nx;
      end
    end
  end

  res_t fin;
  always_comb begin
    stg_t l;
    logic ok;
    l  = stg_q[NS];
    ok = (l.job.status == ST_OK) && !l.job.pul_zero;
    fin        = '0;
    fin.status = l.job.status;
    fin.chan   = l.job.chan;
    if (ok) begin
      fin.tvalid = 1'b1;
      fin.divv   = l.dv;
      fin.perv   = l.qp - 32'd1;
      fin.rise   = l.qp - l.qq;
      fin.fall   = l.qp - 32'd1;
      fin.en     = 1'b1;
      fin.invb   = l.job.inv;
    end
  end

  pwmdc_fifo #(.Width($bits(res_t)), .Depth(2)) u_ofifo (
    .clk_i, .rst_ni,
    .push_i (vld_q[NS]),
    .data_i (fin),
    .full_o (ofull),
    .pop_i  (out_ready_i),
    .data_o (res_o),
    .empty_o(oempty)
  );
  assign out_valid_o = !oempty;
endmodule
`default_nettype wire

[src/pwm_divider_and_edge_calculator.sv]
// Top level of the PWM divider and edge calculator.
// A request passes through 65 pipeline stages (one load stage, 32
// quotient bits for the divider and 32 for the scaling lanes) and is
// then written into the output queue.
// Throughput: one request per cycle; the pipeline stalls only when the
// output queue is full. Reset clears all valid bits and the queues and
// loads channel_count 4, period_bits 16, divider_bits 8.
`default_nettype none
module pwm_divider_and_edge_calculator
  import pwmdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  channel_index_i,
  input  wire logic [31:0] period_cycles_i,
  input  wire logic [31:0] pulse_cycles_i,
  input  wire logic        invert_requested_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status_o,
  output logic [7:0]       target_channel_o,
  output logic             timing_valid_o,
  output logic [31:0]      divider_value_o,
  output logic [31:0]      period_value_o,
  output logic [31:0]      rising_value_o,
  output logic [31:0]      falling_value_o,
  output logic             enable_bit_o,
  output logic             invert_bit_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [7:0] chan_cnt_q;
  logic [5:0] pbits_q, dbits_q;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= 8'd4;
      pbits_q    <= 6'd16;
      dbits_q    <= 6'd8;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 8'(CFG_CHANNEL_COUNT)) begin
        chan_cnt_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == 8'(CFG_PERIOD_BITS)) begin
        pbits_q <= cfg_data_i[5:0];
      end else if (cfg_index_i == 8'(CFG_DIVIDER_BITS)) begin
        dbits_q <= cfg_data_i[5:0];
      end
    end
  end

  // The front end classifies each request in the cycle it is pushed.
  job_t job;
  pwmdc_front u_front (
    .chan_cnt_i(chan_cnt_q), .pbits_i(pbits_q), .dbits_i(dbits_q),
    .chan_i(channel_index_i), .per_i(period_cycles_i),
    .pul_i(pulse_cycles_i), .inv_i(invert_requested_i), .job_o(job)
  );

  // A short queue decouples request acceptance from the divider pipe.
  job_t qjob;
  logic qfull, qempty, bready;
  pwmdc_fifo #(.Width($bits(job_t)), .Depth(2)) u_jfifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(job), .full_o(qfull),
    .pop_i(bready), .data_o(qjob), .empty_o(qempty)
  );
  assign full = qfull;

  res_t res;
  logic ovalid;
  pwmdc_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(!qempty), .job_i(qjob), .in_ready_o(bready),
    .out_valid_o(ovalid), .res_o(res), .out_ready_i(pop)
  );

  assign empty              = !ovalid;
  assign status_o           = res.status;
  assign target_channel_o   = res.chan;
  assign timing_valid_o     = res.tvalid;
  assign divider_value_o    = res.divv;
  assign period_value_o     = res.perv;
  assign rising_value_o     = res.rise;
  assign falling_value_o    = res.fall;
  assign enable_bit_o       = res.en;
  assign invert_bit_o       = res.invb;
endmodule
`default_nettype wire
